### rtl/mbdi_pkg.sv
// shared types and constants of the modbus discrete input response unpacker
package mbdi_pkg;

  // default size of the local discrete store in bits
  localparam int STORE_BITS_DEFAULT = 1024;

  // queue depths between front, back and result port
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // width of a store byte index before range check (covers the largest store plus one)
  localparam int BYTE_IDX_W = 14;

  // saturation point of the byte position counter
  localparam logic [7:0] POS_MAX = 8'd255;

  // action codes of an input item
  localparam logic ACT_PDU  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [1:0] {
    EXC_NONE    = 2'd0,
    EXC_VALUE   = 2'd1,
    EXC_ADDRESS = 2'd2
  } exc_t;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_STATUS = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  pdu_byte;
    logic        frame_last;
    logic [15:0] request_address;
    logic [15:0] request_count;
    logic [6:0]  read_index;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  exception_code;
    logic [15:0] value_count;
    logic [7:0]  read_data;
  } result_t;

  // command from the front to the back; a write spans two store bytes
  typedef struct packed {
    cmd_kind_t              kind;
    logic                   has_status;
    logic [BYTE_IDX_W-1:0]  byte_index;
    logic [15:0]            mask;
    logic [15:0]            data;
    exc_t                   exception_code;
    logic [15:0]            value_count;
  } cmd_t;

endpackage

### rtl/mbdi_ram.sv
// generic simple dual port ram with registered read
module mbdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

### rtl/mbdi_fifo.sv
// small generic queue with occupancy count
module mbdi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (level == LVL_W'(DEPTH));
  assign empty   = (level == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      level <= level + LVL_W'(do_push) - LVL_W'(do_pop);
    end
  end

endmodule

### rtl/mbdi_front.sv
// front end: frame tracking, header checks and command generation
module mbdi_front #(
  parameter int STORE_BITS = mbdi_pkg::STORE_BITS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [15:0]     cfg_data,
  input  logic            accept,
  input  mbdi_pkg::item_t item,
  output logic            cmd_push,
  output mbdi_pkg::cmd_t  cmd
);

  localparam int STORE_BYTES = STORE_BITS / 8;
  localparam int IW = mbdi_pkg::BYTE_IDX_W;

  logic [15:0]          start_addr;
  logic [7:0]           pos;
  logic [7:0]           pos_next;
  logic                 header_ok;
  logic                 header_ok_next;
  mbdi_pkg::exc_t       pend_exc;
  mbdi_pkg::exc_t       pend_exc_next;

  logic [IW-1:0]        nbytes;
  logic [16:0]          req_end;
  logic [16:0]          store_end;
  logic                 addr_below;
  logic [15:0]          offset;
  logic [7:0]           j;
  logic                 in_data;
  logic                 wr_ok;
  logic [7:0]           mask8;
  mbdi_pkg::exc_t       hdr_exc;
  mbdi_pkg::exc_t       end_exc;

  assign cfg_ready = 1'b1;

  // start address register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_addr <= '0;
    end else if (cfg_valid) begin
      start_addr <= cfg_data;
    end
  end

  // header checks and data byte placement
  always_comb begin
    nbytes     = {1'b0, item.request_count[15:3]} + IW'(item.request_count[2:0] != 3'd0);
    req_end    = {1'b0, item.request_address} + {1'b0, item.request_count};
    store_end  = {1'b0, start_addr} + 17'(STORE_BITS);
    addr_below = item.request_address < start_addr;
    offset     = item.request_address - start_addr;
    j          = pos - 8'd2;
    in_data    = pos inside {[8'd2:8'd254]};
    wr_ok      = (item.action == mbdi_pkg::ACT_PDU) && in_data && header_ok &&
                 ({6'b0, j} < nbytes) && !addr_below;

    if (item.request_count == 16'd0 || nbytes[7:0] != item.pdu_byte) begin
      hdr_exc = mbdi_pkg::EXC_VALUE;
    end else if (addr_below || req_end > store_end) begin
      hdr_exc = mbdi_pkg::EXC_ADDRESS;
    end else begin
      hdr_exc = mbdi_pkg::EXC_NONE;
    end

    // final partial byte writes only the low count mod 8 bits
    if ({5'b0, j} == item.request_count[15:3] && item.request_count[2:0] != 3'd0) begin
      mask8 = (8'd1 << item.request_count[2:0]) - 8'd1;
    end else begin
      mask8 = 8'hFF;
    end

    // a frame that ends on its byte count reports the header check of that byte
    end_exc = (pos == 8'd0) ? mbdi_pkg::EXC_VALUE :
              (pos == 8'd1) ? hdr_exc : pend_exc;
  end

  // command toward the back end
  always_comb begin
    cmd.kind           = mbdi_pkg::CMD_STATUS;
    cmd.has_status     = item.frame_last;
    cmd.byte_index     = IW'(offset[15:3]) + IW'(j);
    cmd.mask           = {8'b0, mask8} << offset[2:0];
    cmd.data           = {8'b0, item.pdu_byte} << offset[2:0];
    cmd.exception_code = end_exc;
    cmd.value_count    = (end_exc == mbdi_pkg::EXC_NONE) ? item.request_count : 16'd0;
    cmd_push           = 1'b0;
    if (item.action == mbdi_pkg::ACT_READ) begin
      cmd.kind       = mbdi_pkg::CMD_READ;
      cmd.byte_index = IW'(item.read_index) & IW'(STORE_BYTES - 1);
      cmd_push       = accept;
    end else if (wr_ok) begin
      cmd.kind = mbdi_pkg::CMD_WRITE;
      cmd_push = accept;
    end else if (item.frame_last) begin
      cmd_push = accept;
    end
  end

  // frame state next values
  always_comb begin
    pos_next       = pos;
    header_ok_next = header_ok;
    pend_exc_next  = pend_exc;
    if (pos == 8'd1) begin
      header_ok_next = (hdr_exc == mbdi_pkg::EXC_NONE);
      pend_exc_next  = hdr_exc;
    end
    if (item.frame_last) begin
      pos_next       = '0;
      header_ok_next = 1'b0;
      pend_exc_next  = mbdi_pkg::EXC_NONE;
    end else if (pos != mbdi_pkg::POS_MAX) begin
      pos_next = pos + 8'd1;
    end
  end

  // frame state registers, moved only by received bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      header_ok <= 1'b0;
      pend_exc  <= mbdi_pkg::EXC_NONE;
    end else if (accept && item.action == mbdi_pkg::ACT_PDU) begin
      pos       <= pos_next;
      header_ok <= header_ok_next;
      pend_exc  <= pend_exc_next;
    end
  end

endmodule

### rtl/mbdi_back.sv
// back end: store clearing, read-modify-write of store bytes and result build
module mbdi_back #(
  parameter int STORE_BITS = mbdi_pkg::STORE_BITS_DEFAULT
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cmd_valid,
  input  mbdi_pkg::cmd_t                              cmd,
  output logic                                        cmd_pop,
  input  logic [$clog2(mbdi_pkg::OUT_DEPTH+1)-1:0]    out_level,
  output logic                                        out_push,
  output mbdi_pkg::result_t                           out_item,
  output logic                                        clearing
);

  localparam int STORE_BYTES = STORE_BITS / 8;
  localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int IW = mbdi_pkg::BYTE_IDX_W;
  localparam int LVL_W = $clog2(mbdi_pkg::OUT_DEPTH + 1);

  logic [ADDR_W-1:0]  clr_idx;
  logic               phase;

  // issue stage
  logic [IW-1:0]      op_idx;
  logic [7:0]         op_mask;
  logic [7:0]         op_data;
  logic               op_we;
  logic               op_res;
  logic               op_last;
  logic               op_read;
  logic               space;
  logic               issue;
  logic [ADDR_W-1:0]  raddr;

  // write stage
  logic               s1_valid;
  logic               s1_we;
  logic               s1_res;
  logic               s1_read;
  logic [ADDR_W-1:0]  s1_addr;
  logic [7:0]         s1_mask;
  logic [7:0]         s1_data;
  logic [1:0]         s1_exc;
  logic [15:0]        s1_count;
  logic               fwd_hit;
  logic [7:0]         fwd_data;
  logic [7:0]         ram_rdata;
  logic [7:0]         cur;
  logic [7:0]         merged;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [7:0]         ram_wdata;

  // decode the head command into one store byte operation
  always_comb begin
    op_idx  = cmd.byte_index;
    op_mask = cmd.mask[7:0];
    op_data = cmd.data[7:0];
    op_res  = 1'b1;
    op_last = 1'b1;
    op_read = 1'b0;
    op_we   = 1'b0;
    case (cmd.kind)
      mbdi_pkg::CMD_READ: begin
        op_read = 1'b1;
      end
      mbdi_pkg::CMD_WRITE: begin
        if (phase) begin
          op_idx  = cmd.byte_index + IW'(1);
          op_mask = cmd.mask[15:8];
          op_data = cmd.data[15:8];
        end
        op_we   = op_idx < IW'(STORE_BYTES);
        op_res  = phase && cmd.has_status;
        op_last = phase;
      end
      mbdi_pkg::CMD_STATUS: begin
        op_res = 1'b1;
      end
      default: begin
        op_res = 1'b0;
      end
    endcase
    raddr = op_idx[ADDR_W-1:0];
    space = (out_level + LVL_W'(s1_valid && s1_res)) < LVL_W'(mbdi_pkg::OUT_DEPTH);
    issue = cmd_valid && !clearing && (!op_res || space);
    cmd_pop = issue && op_last;
  end

  // clearing pass after reset and write phase
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
      phase    <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + ADDR_W'(1);
        if (clr_idx == ADDR_W'(STORE_BYTES - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (issue) begin
        phase <= (cmd.kind == mbdi_pkg::CMD_WRITE) && !phase;
      end
    end
  end

  // write stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
  end

  // write stage payload; forward a byte written in the issue cycle
  always_ff @(posedge clk) begin
    s1_we    <= op_we;
    s1_res   <= op_res;
    s1_read  <= op_read;
    s1_addr  <= raddr;
    s1_mask  <= op_mask;
    s1_data  <= op_data;
    s1_exc   <= (cmd.kind == mbdi_pkg::CMD_READ) ? mbdi_pkg::EXC_NONE : cmd.exception_code;
    s1_count <= (cmd.kind == mbdi_pkg::CMD_READ) ? 16'd0 : cmd.value_count;
    fwd_hit  <= s1_valid && s1_we && (s1_addr == raddr);
    fwd_data <= merged;
  end

  // merge new bits into the current store byte
  always_comb begin
    cur    = fwd_hit ? fwd_data : ram_rdata;
    merged = (cur & ~s1_mask) | (s1_data & s1_mask);
  end

  // ram write port shared by clearing pass and data writes
  always_comb begin
    ram_we    = clearing || (s1_valid && s1_we);
    ram_waddr = clearing ? clr_idx : s1_addr;
    ram_wdata = clearing ? 8'd0 : merged;
  end

  mbdi_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // result transaction
  always_comb begin
    out_push                = s1_valid && s1_res;
    out_item.result_kind    = s1_read ? mbdi_pkg::KIND_READ : mbdi_pkg::KIND_STATUS;
    out_item.exception_code = s1_exc;
    out_item.value_count    = s1_count;
    out_item.read_data      = s1_read ? cur : 8'd0;
  end

endmodule

### rtl/modbus_discrete_input_response_unpack.sv
// Modbus read-discrete-inputs response unpacker, top level.
// Push one item per cycle while full is low: a response PDU byte (function
// code, byte count, then packed bits, with frame_last on the final byte) or a
// read of one store byte. The front end checks the header on the byte-count
// byte and turns each item into a command; a four-entry command queue
// decouples it from the back end, which owns the single-write-port store RAM.
// A read or an end-of-frame status is one back-end operation; a data byte is
// two, one read-modify-write per store byte it may straddle. A result passes
// through the command queue and the back end's issue and write stages (a
// frame ending on a written data byte reports with its second operation),
// then waits in a four-entry result queue. After reset the store is cleared
// one byte per cycle, all STORE_BITS/8 bytes (128 by default), while full
// stays high; configuration writes are taken at any time and must only be
// issued while the block is idle.
module modbus_discrete_input_response_unpack #(
  parameter int STORE_BITS = mbdi_pkg::STORE_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data,
  input  logic              push,
  output logic              full,
  input  mbdi_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output mbdi_pkg::result_t result
);

  localparam int CMD_W = $bits(mbdi_pkg::cmd_t);
  localparam int RES_W = $bits(mbdi_pkg::result_t);

  logic                                      accept;
  logic                                      cmd_push;
  mbdi_pkg::cmd_t                            cmd_in;
  logic [CMD_W-1:0]                          cmd_raw;
  mbdi_pkg::cmd_t                            cmd_head;
  logic                                      cmd_full;
  logic                                      cmd_empty;
  logic                                      cmd_pop;
  logic [$clog2(mbdi_pkg::CMD_DEPTH+1)-1:0]  cmd_level;
  logic                                      out_push;
  mbdi_pkg::result_t                         out_item;
  logic                                      out_full;
  logic [RES_W-1:0]                          out_raw;
  logic [$clog2(mbdi_pkg::OUT_DEPTH+1)-1:0]  out_level;
  logic                                      clearing;

  assign full     = cmd_full || clearing;
  assign accept   = push && !full;
  assign cmd_head = mbdi_pkg::cmd_t'(cmd_raw);
  assign result   = mbdi_pkg::result_t'(out_raw);

  mbdi_front #(
    .STORE_BITS (STORE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (item),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  mbdi_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (mbdi_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_raw),
    .empty (cmd_empty),
    .level (cmd_level)
  );

  mbdi_back #(
    .STORE_BITS (STORE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty && (cmd_level != '0)),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_level (out_level),
    .out_push  (out_push),
    .out_item  (out_item),
    .clearing  (clearing)
  );

  mbdi_fifo #(
    .WIDTH (RES_W),
    .DEPTH (mbdi_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push && !out_full),
    .wdata (out_item),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_raw),
    .empty (empty),
    .level (out_level)
  );

endmodule

### tb/sv/modbus_discrete_input_response_unpack_test.sv
// testbench of the modbus discrete input response unpacker: directed and random frames, self-checking
`timescale 1ns / 1ps

module modbus_discrete_input_response_unpack_test;
  import mbdi_pkg::*;

  localparam int STORE_BITS = STORE_BITS_DEFAULT;
  localparam int STORE_BYTES = STORE_BITS / 8;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int QUIET_LIMIT = 5000;
  localparam logic [7:0] FC_READ_DISCRETE = 8'h02;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  item_t item_in = '0;
  logic empty;
  logic pop = 1'b0;
  result_t result_out;

  // shadow copy of the block state
  logic [7:0] shadow_store [STORE_BYTES];
  logic [7:0] shadow_pos;
  bit shadow_header_ok;
  exc_t shadow_pending;
  logic [15:0] shadow_start;

  result_t expected_results [$];
  int errors = 0;
  int items_sent = 0;
  int frames_sent = 0;
  int results_checked = 0;
  int start_settings = 0;
  int quiet_cycles = 0;
  bit input_gaps = 1'b0;
  bit output_gaps = 1'b0;
  bit hold_results = 1'b0;
  logic [15:0] store_base = '0;

  modbus_discrete_input_response_unpack uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .item(item_in),
    .empty(empty),
    .pop(pop),
    .result(result_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned bytes_needed(input int unsigned n);
    return (n >> 3) + (((n & 32'h7) != 0) ? 1 : 0);
  endfunction

  // advance the shadow state by one item; returns 1 when a result is due
  function automatic bit predict_response(input item_t it, output result_t res);
    int unsigned cnt, adr, nbytes, off, nbits, j, bitpos;
    exc_t code;
    res = '0;
    if (it.action == ACT_READ) begin
      res.result_kind = KIND_READ;
      res.read_data = shadow_store[it.read_index];
      return 1'b1;
    end
    cnt = it.request_count;
    adr = it.request_address;
    nbytes = bytes_needed(cnt);
    // header checks on the byte count, then data writes
    if (shadow_pos == 8'd1) begin
      if (cnt == 0 || (nbytes & 32'hFF) != it.pdu_byte) begin
        shadow_pending = EXC_VALUE;
        shadow_header_ok = 1'b0;
      end else if (adr < shadow_start || adr + cnt > shadow_start + STORE_BITS) begin
        shadow_pending = EXC_ADDRESS;
        shadow_header_ok = 1'b0;
      end else begin
        shadow_pending = EXC_NONE;
        shadow_header_ok = 1'b1;
      end
    end else if (shadow_pos >= 8'd2 && shadow_pos < POS_MAX && shadow_header_ok) begin
      j = shadow_pos - 2;
      if (j < nbytes && adr >= shadow_start) begin
        off = adr - shadow_start;
        nbits = (j == (cnt >> 3) && (cnt & 32'h7) != 0) ? (cnt & 32'h7) : 8;
        for (int k = 0; k < nbits; k++) begin
          bitpos = off + 8 * j + k;
          if (bitpos < STORE_BITS) shadow_store[bitpos / 8][bitpos % 8] = it.pdu_byte[k];
        end
      end
    end
    // frame end reports status and clears the frame state
    if (it.frame_last) begin
      code = (shadow_pos == 8'd0) ? EXC_VALUE : shadow_pending;
      res.result_kind = KIND_STATUS;
      res.exception_code = code;
      res.value_count = (code == EXC_NONE) ? it.request_count : 16'd0;
      shadow_pos = '0;
      shadow_header_ok = 1'b0;
      shadow_pending = EXC_NONE;
      return 1'b1;
    end
    if (shadow_pos < POS_MAX) shadow_pos++;
    return 1'b0;
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result with nothing expected, expected none, actual %p", $time, got);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
    compare_field("exception_code", 16'(want.exception_code), 16'(got.exception_code));
    compare_field("value_count", want.value_count, got.value_count);
    compare_field("read_data", 16'(want.read_data), 16'(got.read_data));
    results_checked++;
  endtask

  // sample every transaction at the edge, predict and check
  always @(posedge clk) begin : scoreboard
    result_t want;
    bit progress;
    progress = 1'b0;
    if (rst) begin
      for (int i = 0; i < STORE_BYTES; i++) shadow_store[i] = '0;
      shadow_pos = '0;
      shadow_header_ok = 1'b0;
      shadow_pending = EXC_NONE;
      shadow_start = '0;
      quiet_cycles = 0;
    end else begin
      if (pop && !empty) begin
        check_result(result_out);
        progress = 1'b1;
      end
      if (push && !full) begin
        if (predict_response(item_in, want)) expected_results.push_back(want);
        progress = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        shadow_start = cfg_data;
        progress = 1'b1;
      end
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("FAIL modbus_discrete_input_response_unpack");
    $finish;
  end

  function automatic int gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // result side: random pop gaps, plus one long hold on request
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_results) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
        pop <= 1'b1;
      end else if (output_gaps && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat (gap_length()) @(posedge clk);
        pop <= 1'b1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic item_t pdu_item(input logic [7:0] b, input logic last,
                                     input logic [15:0] adr, input logic [15:0] cnt);
    item_t it;
    it.action = ACT_PDU;
    it.pdu_byte = b;
    it.frame_last = last;
    it.request_address = adr;
    it.request_count = cnt;
    it.read_index = 7'($urandom);
    return it;
  endfunction

  function automatic item_t read_item(input logic [6:0] idx);
    item_t it;
    it.action = ACT_READ;
    it.pdu_byte = 8'($urandom);
    it.frame_last = 1'($urandom);
    it.request_address = 16'($urandom);
    it.request_count = 16'($urandom);
    it.read_index = idx;
    return it;
  endfunction

  // one input transaction; push stays high when the next item follows at once
  task automatic send_item(input item_t it);
    if (input_gaps && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat (gap_length()) @(posedge clk);
    end
    item_in <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  // function code, byte count, then data; stirred frames vary request fields and mix in reads
  task automatic send_frame(input logic [15:0] adr, input logic [15:0] cnt,
                            input logic [7:0] count_byte, input int n_bytes, input bit stirred);
    logic [7:0] b;
    logic [15:0] a, c;
    for (int i = 0; i < n_bytes; i++) begin
      a = adr;
      c = cnt;
      if (i == 0) b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : FC_READ_DISCRETE;
      else if (i == 1) b = count_byte;
      else b = 8'($urandom);
      if (stirred && i >= 2 && $urandom_range(0, 5) == 0) begin
        a = 16'(adr + $urandom_range(0, 1100) - 50);
        if ($urandom_range(0, 1) == 1) c = 16'($urandom_range(0, 1100));
      end
      if (stirred && $urandom_range(0, 7) == 0) send_item(read_item(7'($urandom)));
      send_item(pdu_item(b, i == n_bytes - 1, a, c));
    end
    frames_sent++;
  endtask

  // wait until every result is back and the data path has gone quiet
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_address(input logic [15:0] base);
    settle();
    cfg_data <= base;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    store_base = base;
    start_settings++;
  endtask

  task automatic test_header_checks();
    write_start_address(16'd0);
    send_frame(16'd0, 16'd8, 8'd1, 1, 1'b0);       // frame too short
    send_frame(16'd0, 16'd8, 8'd1, 2, 1'b0);       // header only, no data
    send_frame(16'd0, 16'd0, 8'd0, 2, 1'b0);       // zero count
    send_frame(16'd0, 16'd9, 8'd1, 2, 1'b0);       // byte count mismatch
    send_frame(16'd0, 16'd2048, 8'd0, 2, 1'b0);    // byte count wraps, then address fails
    send_frame(16'd1000, 16'd40, 8'd5, 2, 1'b0);   // range past the store end
  endtask

  task automatic test_data_writes();
    // unaligned frame with a partial last byte and a read in the middle
    send_item(pdu_item(FC_READ_DISCRETE, 1'b0, 16'd3, 16'd13));
    send_item(pdu_item(8'd2, 1'b0, 16'd3, 16'd13));
    send_item(pdu_item(8'hA5, 1'b0, 16'd3, 16'd13));
    send_item(read_item(7'd0));
    send_item(pdu_item(8'h3C, 1'b1, 16'd3, 16'd13));
    send_item(read_item(7'd0));
    send_item(read_item(7'd127));
    send_frame(16'd16, 16'd5, 8'd1, 5, 1'b0);      // extra data bytes
    send_frame(16'd40, 16'd20, 8'd3, 3, 1'b0);     // missing data bytes
  endtask

  task automatic test_below_start();
    write_start_address(16'd200);
    send_frame(16'd100, 16'd8, 8'd1, 3, 1'b0);
    send_frame(16'd200, 16'd8, 8'd1, 3, 1'b0);
  endtask

  // full store in one frame, run past the position counter saturation
  task automatic test_long_frame();
    write_start_address(16'd0);
    send_frame(16'd0, 16'd1024, 8'd128, 260, 1'b0);
    repeat (4) send_item(read_item(7'($urandom)));
  endtask

  task automatic send_good_frame();
    int unsigned r, cnt, lim, nb, ndata;
    logic [15:0] adr;
    r = $urandom_range(0, 99);
    cnt = (r < 80) ? $urandom_range(1, 40) :
          (r < 97) ? $urandom_range(41, 200) : $urandom_range(201, 1024);
    lim = STORE_BITS - cnt;
    if (lim > 32'hFFFF - store_base) lim = 32'hFFFF - store_base;
    adr = 16'(store_base + $urandom_range(0, lim));
    nb = bytes_needed(cnt);
    r = $urandom_range(0, 9);
    ndata = (r == 0) ? nb + $urandom_range(1, 3) : (r == 1) ? $urandom_range(0, nb - 1) : nb;
    send_frame(adr, 16'(cnt), 8'(nb), 2 + ndata, $urandom_range(0, 3) == 0);
  endtask

  task automatic send_broken_frame();
    logic [15:0] adr, cnt;
    logic [7:0] bc;
    adr = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                      : 16'(store_base + $urandom_range(0, 1100) - 20);
    cnt = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
    bc = ($urandom_range(0, 1) == 0) ? 8'(bytes_needed(cnt)) : 8'($urandom);
    send_frame(adr, cnt, bc, $urandom_range(1, 6), 1'b1);
  endtask

  task automatic random_frames(input int n_items);
    int stop;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1: send_broken_frame();
        2: repeat ($urandom_range(1, 4)) send_item(read_item(7'($urandom)));
        default: send_good_frame();
      endcase
    end
  endtask

  task automatic test_random_settings();
    logic [15:0] bases [4];
    bases = '{16'd0, 16'hFFFF, 16'($urandom), 16'd1000};
    foreach (bases[i]) begin
      write_start_address(bases[i]);
      input_gaps = (i != 0);
      output_gaps = (i != 0) && (i != 2);
      random_frames(150);
    end
  endtask

  // receiver holds off while reads keep coming, so the block fills and stalls
  task automatic test_backpressure();
    input_gaps = 1'b0;
    hold_results = 1'b1;
    repeat (40) send_item(read_item(7'($urandom)));
    wait (!hold_results);
  endtask

  initial begin : run
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_header_checks();
    test_data_writes();
    test_below_start();
    test_long_frame();
    test_random_settings();
    test_backpressure();
    settle();
    $display("sent %0d items in %0d frames over %0d start addresses, checked %0d results",
             items_sent, frames_sent, start_settings, results_checked);
    $display("covered header errors, partial and extra data, saturation and a long result stall");
    if (errors == 0) begin
      $display("PASS modbus_discrete_input_response_unpack");
    end else begin
      $display("FAIL modbus_discrete_input_response_unpack");
    end
    $finish;
  end

endmodule
